>>> rtl/lru_glyph_tag_cache_assert.svh
// ----------------------------------------------------------------------------
// lru_glyph_tag_cache_assert.svh - assertion macros
// Shorthand for the concurrent checks at the end of the glyph tag cache.
// ----------------------------------------------------------------------------
`ifndef LRU_GLYPH_TAG_CACHE_ASSERT_SVH
`define LRU_GLYPH_TAG_CACHE_ASSERT_SVH

// Check clocked on clk, switched off while rst_n is low.
`define LGTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check clocked on clk that also holds across reset.
`define LGTC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lgtc_pkg.sv
// ----------------------------------------------------------------------------
// lgtc_pkg - glyph tag cache package
// Command codes, sequencer states, word layouts and compare flags.
// ----------------------------------------------------------------------------
package lgtc_pkg;

  localparam int CODE_W      = 16;
  localparam int SLOT_W      = 6;
  localparam int CMD_W       = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (CODE_W + SLOT_W + 3);

  localparam logic [CMD_W-1:0] CMD_PROBE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } lgtc_state_t;

  // flags from the shared compare unit for one entry
  typedef struct packed {
    logic code_eq;   // stored tag equals the looked-up code
    logic rank_lt;   // rank younger than the reference rank
    logic rank_last; // rank is the oldest in use (fill - 1)
  } lgtc_cmp_t;

endpackage

>>> rtl/lgtc_cmp_unit.sv
// ----------------------------------------------------------------------------
// lgtc_cmp_unit - shared tag and rank compare
// One entry per cycle: tag match, rank order tests and the aged rank.
// ----------------------------------------------------------------------------
module lgtc_cmp_unit #(
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  logic [lgtc_pkg::CODE_W-1:0] entry_code,
  input  logic [lgtc_pkg::CODE_W-1:0] look_code,
  input  logic [IW-1:0]               rank,
  input  logic [IW-1:0]               ref_rank,
  input  logic [CW-1:0]               fill,
  output lgtc_pkg::lgtc_cmp_t         flags,
  output logic [IW-1:0]               rank_inc
);
  import lgtc_pkg::*;

  always_comb begin
    flags.code_eq   = (entry_code == look_code);
    flags.rank_lt   = (rank < ref_rank);
    flags.rank_last = ((CW'(rank) + CW'(1)) == fill);
    rank_inc        = rank + IW'(1);
  end

endmodule

>>> rtl/lru_glyph_tag_cache.sv
// ----------------------------------------------------------------------------
// lru_glyph_tag_cache - fully associative LRU glyph tag cache
// Holds up to CAPACITY 16-bit character codes with an age rank each;
// probe, access, load (with eviction) and clear commands.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Ports                       Word contents (low bit up)
//  -------   ---  --------------------------  ---------------------------------
//  in_*      in   tvalid/tready/tdata/tuser   tdata: code, in_font; tuser: command
//  out_*     out  tvalid/tready/tdata         hit, slot, inserted, evicted,
//                                             evicted_code
//
//  A probe, or a miss that inserts nothing, makes one sweep from accept to result;
//  an access or load hit, or a load that inserts, makes two, since the tag and
//  rank memories have one read port and are swept one entry a cycle, once to
//  look up and once to re-rank. Clear makes no sweep.
//  Reset (rst_n low, synchronous) empties the cache at once via the valid bits.
//  in_tready is high in idle only; a finished word waits in the output register
//  while the next word can already be taken, and out_tready low stalls the
//  sequencer in its last state while that register still holds a word.
//
module lru_glyph_tag_cache #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: [15:0] code, [16] in_font, [23:17] zero
  input  logic [lgtc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: [1:0] command
  input  logic [lgtc_pkg::CMD_W-1:0]          in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: [0] hit, [6:1] slot, [7] inserted, [8] evicted,
  //        [24:9] evicted_code, [31:25] zero
  output logic [lgtc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready
);
  import lgtc_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1; // entry index
  localparam int CW = $clog2(CAPACITY + 1);                  // count 0..CAPACITY

  // tag and rank stores, one read and one write a cycle
  logic [CODE_W-1:0] code_mem [CAPACITY];
  logic [IW-1:0]     rank_mem [CAPACITY];

  lgtc_state_t       state_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [CODE_W-1:0] code_r;
  logic              font_r;
  logic [CAPACITY-1:0] valid_r;
  logic [CW-1:0]     fill_r;

  // sweep: issue counter and one read pipeline stage
  logic [CW-1:0]     cnt_r;
  logic              pipe_vld_r;
  logic [IW-1:0]     pipe_idx_r;
  logic [CODE_W-1:0] code_q_r;
  logic [IW-1:0]     rank_q_r;

  // scan findings
  logic              hit_found_r;
  logic [IW-1:0]     hit_idx_r;
  logic [IW-1:0]     hit_rank_r;
  logic              free_found_r;
  logic [IW-1:0]     free_idx_r;
  logic              lru_found_r;
  logic [IW-1:0]     lru_idx_r;
  logic [CODE_W-1:0] lru_code_r;

  // re-rank pass
  logic              age_mode_r;  // 1: age every valid entry, 0: touch
  logic [IW-1:0]     tgt_r;

  // result being built
  logic              res_hit_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              res_ins_r;
  logic              res_ev_r;
  logic [CODE_W-1:0] res_evcode_r;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // combinational helpers
  logic              rd_en;
  logic              ent_v;
  lgtc_cmp_t         cmp;
  logic [IW-1:0]     rank_inc;
  logic [IW-1:0]     rank_new;
  logic              full;
  logic              miss_load;
  logic              evict_go;
  logic [CW-1:0]     fill_after;
  logic              ins_go;
  logic [IW-1:0]     ins_idx;
  logic              out_free;

  lgtc_cmp_unit #(
    .IW (IW),
    .CW (CW)
  ) u_cmp (
    .entry_code (code_q_r),
    .look_code  (code_r),
    .rank       (rank_q_r),
    .ref_rank   (hit_rank_r),
    .fill       (fill_r),
    .flags      (cmp),
    .rank_inc   (rank_inc)
  );

  always_comb begin
    rd_en = ((state_r == ST_SCAN) || (state_r == ST_UPDATE)) && (cnt_r != CW'(CAPACITY));
    ent_v = valid_r[pipe_idx_r];

    // new rank during the re-rank pass
    if (pipe_idx_r == tgt_r) begin
      rank_new = '0;
    end else if (ent_v && (age_mode_r || cmp.rank_lt)) begin
      rank_new = rank_inc;
    end else begin
      rank_new = rank_q_r;
    end

    // load miss: evict the oldest when full; an insert takes the evicted entry, else the first free one
    full       = (fill_r == CW'(CAPACITY));
    miss_load  = !hit_found_r && (cmd_r == CMD_LOAD);
    evict_go   = miss_load && full && lru_found_r;
    fill_after = fill_r - CW'(evict_go);
    ins_go     = miss_load && font_r && (fill_after != CW'(CAPACITY));
    ins_idx    = evict_go ? lru_idx_r : free_idx_r;

    out_free   = !out_tvalid_r || out_tready;
  end

  // memories
  always_ff @(posedge clk) begin
    if (rd_en) begin
      code_q_r <= code_mem[cnt_r[IW-1:0]];
      rank_q_r <= rank_mem[cnt_r[IW-1:0]];
    end
    if ((state_r == ST_DECIDE) && ins_go) begin
      code_mem[ins_idx] <= code_r;
    end
    if ((state_r == ST_UPDATE) && pipe_vld_r) begin
      rank_mem[pipe_idx_r] <= rank_new;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      fill_r       <= '0;
      cnt_r        <= '0;
      pipe_vld_r   <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      lru_found_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // the final state reloads the output register itself
      if (out_tready && (state_r != ST_DONE)) begin
        out_tvalid_r <= 1'b0;
      end

      // sweep pipeline advances in either pass
      pipe_vld_r <= rd_en;
      pipe_idx_r <= cnt_r[IW-1:0];
      if (rd_en) begin
        cnt_r <= cnt_r + CW'(1);
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r        <= in_tuser;
            code_r       <= in_tdata[CODE_W-1:0];
            font_r       <= in_tdata[CODE_W];
            res_hit_r    <= 1'b0;
            res_slot_r   <= '0;
            res_ins_r    <= 1'b0;
            res_ev_r     <= 1'b0;
            res_evcode_r <= '0;
            hit_found_r  <= 1'b0;
            free_found_r <= 1'b0;
            lru_found_r  <= 1'b0;
            cnt_r        <= '0;
            if (in_tuser == CMD_CLEAR) begin
              valid_r <= '0;
              fill_r  <= '0;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          if (pipe_vld_r) begin
            if (ent_v && cmp.code_eq && !hit_found_r) begin
              hit_found_r <= 1'b1;
              hit_idx_r   <= pipe_idx_r;
              hit_rank_r  <= rank_q_r;
            end
            if (!ent_v && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= pipe_idx_r;
            end
            if (ent_v && cmp.rank_last && !lru_found_r) begin
              lru_found_r <= 1'b1;
              lru_idx_r   <= pipe_idx_r;
              lru_code_r  <= code_q_r;
            end
          end else if (cnt_r == CW'(CAPACITY)) begin
            state_r <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          cnt_r <= '0;
          if (hit_found_r) begin
            res_hit_r  <= 1'b1;
            res_slot_r <= SLOT_W'(hit_idx_r);
            age_mode_r <= 1'b0;
            tgt_r      <= hit_idx_r;
            state_r    <= (cmd_r == CMD_PROBE) ? ST_DONE : ST_UPDATE;
          end else begin
            if (evict_go) begin
              // an insert reuses the evicted entry and keeps it valid
              if (!ins_go) begin
                valid_r[lru_idx_r] <= 1'b0;
              end
              res_ev_r     <= 1'b1;
              res_evcode_r <= lru_code_r;
            end
            fill_r <= fill_after + CW'(ins_go);
            if (ins_go) begin
              valid_r[ins_idx] <= 1'b1;
              res_ins_r        <= 1'b1;
              res_slot_r       <= SLOT_W'(ins_idx);
              age_mode_r       <= 1'b1;
              tgt_r            <= ins_idx;
              state_r          <= ST_UPDATE;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end

        ST_UPDATE: begin
          if (!pipe_vld_r && (cnt_r == CW'(CAPACITY))) begin
            state_r <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {{OUT_PAD_W{1'b0}}, res_evcode_r, res_ev_r, res_ins_r,
                             res_slot_r, res_hit_r};
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  `include "lru_glyph_tag_cache_assert.svh"

  `LGTC_ASSERT(a_fill_matches_valid, (state_r == ST_IDLE) |-> (fill_r == CW'($countones(valid_r))), "fill count out of step with valid bits")
  `LGTC_ASSERT(a_clear_empties, (in_tvalid && in_tready && (in_tuser == CMD_CLEAR)) |=> (valid_r == '0), "clear left entries valid")
  `LGTC_ASSERT(a_result_from_done, $rose(out_tvalid_r) |-> $past(state_r == ST_DONE), "result word raised outside the final state")
  `LGTC_ASSERT_RST(a_reset_idle, !rst_n |=> ((state_r == ST_IDLE) && !out_tvalid_r), "reset did not return to idle")

endmodule

>>> dv/tb_lru_glyph_tag_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_glyph_tag_cache - self-checking bench for the LRU glyph tag cache
// Drives command words through the input stream and keeps its own copy of
// the tags, valid bits, age ranks and fill level. Every result word is
// checked against the prediction. A directed run of corner cases is followed
// by random traffic over a small code pool, so the cache fills, evicts and
// re-ranks. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_lru_glyph_tag_cache;
  import lgtc_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int N_RANDOM     = 700;
  localparam int POOL_SIZE    = 80;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
  // cycles in this window run with no stalls on either side
  localparam int CALM_FROM    = 30000;
  localparam int CALM_TO      = 60000;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [CODE_W-1:0] code;
    logic              in_font;
  } glyph_req_t;

  typedef struct {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              inserted;
    logic              evicted;
    logic [CODE_W-1:0] ev_code;
  } glyph_res_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  lru_glyph_tag_cache #(.CAPACITY(CAPACITY)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  glyph_req_t pending_reqs[$];
  glyph_res_t expected_results[$];
  glyph_req_t cur_req;
  int         fail_count = 0;
  int         cycle_no = 0;
  int         n_total = 0;
  int         n_checked = 0;

  // shadow copy of the cache contents
  logic [CODE_W-1:0] shadow_code [CAPACITY];
  logic              shadow_valid[CAPACITY];
  logic [SLOT_W-1:0] shadow_rank [CAPACITY];
  logic [6:0]        shadow_fill;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_no <= cycle_no + 1;

  function automatic logic stall_now();
    if (cycle_no >= CALM_FROM && cycle_no < CALM_TO) return 1'b0;
    return $urandom_range(99) < 33;
  endfunction

  task automatic shadow_clear();
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_code[i]  = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = '0;
    end
    shadow_fill = '0;
  endtask

  // Work out the result of one command and update the shadow copy.
  task automatic lookup_and_update(input glyph_req_t rq, output glyph_res_t rs);
    int          idx;
    logic [SLOT_W-1:0] ref_rank;
    rs = '{default: '0};
    idx = -1;
    if (rq.cmd == CMD_CLEAR) begin
      shadow_clear();
      return;
    end
    for (int i = 0; i < CAPACITY; i++)
      if (idx < 0 && shadow_valid[i] && shadow_code[i] == rq.code) idx = i;
    if (idx >= 0) begin
      rs.hit  = 1'b1;
      rs.slot = SLOT_W'(idx);
      if (rq.cmd != CMD_PROBE) begin
        // touch: everything younger than the hit ages by one
        ref_rank = shadow_rank[idx];
        for (int i = 0; i < CAPACITY; i++)
          if (shadow_valid[i] && shadow_rank[i] < ref_rank)
            shadow_rank[i] = shadow_rank[i] + 1'b1;
        shadow_rank[idx] = '0;
      end
    end else if (rq.cmd == CMD_LOAD) begin
      // full cache: the oldest entry goes, even if the font lacks the code
      if (shadow_fill >= 7'(CAPACITY)) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (!rs.evicted && shadow_valid[i] &&
              7'(shadow_rank[i]) == shadow_fill - 7'd1) begin
            rs.evicted      = 1'b1;
            rs.ev_code      = shadow_code[i];
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = '0;
            shadow_fill     = shadow_fill - 7'd1;
          end
        end
      end
      if (rq.in_font && shadow_fill < 7'(CAPACITY)) begin
        idx = -1;
        for (int i = 0; i < CAPACITY; i++)
          if (idx < 0 && !shadow_valid[i]) idx = i;
        if (idx >= 0) begin
          for (int j = 0; j < CAPACITY; j++)
            if (shadow_valid[j]) shadow_rank[j] = shadow_rank[j] + 1'b1;
          shadow_valid[idx] = 1'b1;
          shadow_code[idx]  = rq.code;
          shadow_rank[idx]  = '0;
          shadow_fill       = shadow_fill + 7'd1;
          rs.inserted       = 1'b1;
          rs.slot           = SLOT_W'(idx);
        end
      end
    end
  endtask

  task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                           input logic in_font);
    glyph_req_t rq;
    rq.cmd     = cmd;
    rq.code    = code;
    rq.in_font = in_font;
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // Driver: presents the next pending word, predicts on each accept.
  always @(posedge clk) begin
    glyph_res_t rs;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        lookup_and_update(cur_req, rs);
        expected_results.insert(expected_results.size(), rs);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && !stall_now()) begin
          cur_req   = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, cur_req.in_font, cur_req.code};
          in_tuser  <= cur_req.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, field-by-field compare of each word.
  always @(posedge clk) begin
    glyph_res_t want;
    logic              got_hit, got_ins, got_ev;
    logic [SLOT_W-1:0] got_slot;
    logic [CODE_W-1:0] got_code;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_checked++;
        got_hit  = out_tdata[0];
        got_slot = out_tdata[6:1];
        got_ins  = out_tdata[7];
        got_ev   = out_tdata[8];
        got_code = out_tdata[24:9];
        if (expected_results.size() == 0) begin
          $error("unexpected result word 0x%08h", out_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got_hit);
            fail_count++;
          end
          if (got_slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got_slot);
            fail_count++;
          end
          if (got_ins !== want.inserted) begin
            $error("inserted: expected %0d, got %0d", want.inserted, got_ins);
            fail_count++;
          end
          if (got_ev !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, got_ev);
            fail_count++;
          end
          if (got_code !== want.ev_code) begin
            $error("evicted_code: expected 0x%04h, got 0x%04h", want.ev_code, got_code);
            fail_count++;
          end
        end
      end
      out_tready <= !stall_now();
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [CODE_W-1:0] pool[POOL_SIZE];
    logic [CODE_W-1:0] code;
    int                roll;
    shadow_clear();

    // directed corner cases
    queue_req(CMD_PROBE,  16'h0000, 1'b0);   // probe on an empty cache
    queue_req(CMD_ACCESS, 16'hFFFF, 1'b1);   // access miss
    queue_req(CMD_LOAD,   16'h1234, 1'b0);   // load miss, font lacks code, not full
    queue_req(CMD_LOAD,   16'h0000, 1'b1);   // lowest code inserted
    queue_req(CMD_LOAD,   16'hFFFF, 1'b1);   // highest code inserted
    queue_req(CMD_LOAD,   16'hAAAA, 1'b1);
    queue_req(CMD_LOAD,   16'h5555, 1'b1);
    queue_req(CMD_PROBE,  16'h0000, 1'b1);   // hit, no re-rank
    queue_req(CMD_ACCESS, 16'h0000, 1'b0);   // oldest becomes newest
    queue_req(CMD_LOAD,   16'hFFFF, 1'b0);   // load hit, flag ignored
    queue_req(CMD_PROBE,  16'h1234, 1'b0);   // never inserted
    queue_req(CMD_ACCESS, 16'h5555, 1'b1);   // access hit on an entry that is not the newest
    queue_req(CMD_PROBE,  16'h8000, 1'b1);   // miss
    queue_req(CMD_CLEAR,  16'hFFFF, 1'b1);   // result all zero
    queue_req(CMD_PROBE,  16'hFFFF, 1'b0);   // gone after clear
    queue_req(CMD_CLEAR,  16'h0000, 1'b0);   // clear of an empty cache
    queue_req(CMD_LOAD,   16'h7FFF, 1'b1);   // first free slot again
    queue_req(CMD_ACCESS, 16'h7FFF, 1'b1);

    // random part: mostly well-formed traffic over a pool a bit larger than
    // the cache, so it fills, evicts and re-ranks; the rest is noise
    pool[0] = 16'h0000;
    pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = CODE_W'($urandom);
    for (int n = 0; n < N_RANDOM; n++) begin
      roll = $urandom_range(99);
      if ($urandom_range(99) < 85) code = pool[$urandom_range(POOL_SIZE - 1)];
      else code = CODE_W'($urandom);
      if (n == N_RANDOM / 2 || $urandom_range(299) == 0)
        queue_req(CMD_CLEAR, CODE_W'($urandom), 1'($urandom));
      else if (roll < 48)
        queue_req(CMD_LOAD, code, $urandom_range(99) < 88);
      else if (roll < 78)
        queue_req(CMD_ACCESS, code, 1'($urandom));
      else
        queue_req(CMD_PROBE, code, 1'($urandom));
    end
    n_total = pending_reqs.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // one result word per command
    while (n_checked < n_total) @(posedge clk);
    // let any stray word show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // overall watchdog
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
